### hdl/greedy_coin_change_with_stock_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the greedy coin change unit
// Shared helpers that wrap a clocked, reset-qualified concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef GREEDY_COIN_CHANGE_WITH_STOCK_UNIT_DEFINES_SVH
`define GREEDY_COIN_CHANGE_WITH_STOCK_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define GCCS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define GCCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/gccs_pkg.sv
// ----------------------------------------------------------------------------
// gccs_pkg
// Types and codes shared by the greedy coin change unit and its checker.
// ----------------------------------------------------------------------------
package gccs_pkg;

	// Request kinds carried on the input tuser.
	localparam logic [1:0] MODE_LOAD    = 2'd0;
	localparam logic [1:0] MODE_LIMITED = 2'd1;
	localparam logic [1:0] MODE_FREE    = 2'd2;

	// Field widths fixed by the interface.
	localparam int unsigned SLOT_W  = 3;
	localparam int unsigned VALUE_W = 10;
	localparam int unsigned STOCK_W = 10;
	localparam int unsigned AMT_W   = 16;
	localparam int unsigned CNT_W   = 16;
	localparam int unsigned CFG_W   = 4;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SLOT,
		ST_DIV,
		ST_FIX,
		ST_SUB,
		ST_EMIT
	} state_t;

endpackage

### hdl/greedy_coin_change_with_stock_unit.sv
// ----------------------------------------------------------------------------
// greedy_coin_change_with_stock_unit
// Coin dispenser: greedy change over a table of coin values with stock.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one request per transaction. s_tuser selects the
// kind: a load writes coin value and stock of one slot and gives no result;
// a limited or free change request walks the slots in use and gives one
// result transaction per slot on the master stream, the final one with tlast.
// cfg_we/cfg_wdata set the number of slots in use; write it only when idle.
// Sequencing: a change request is worked on by one shared restoring divider,
// one quotient bit a cycle. Every slot passes a setup step; a slot with a
// nonzero value then runs the divide steps, a step to settle its count and a
// further step when stock caps the count. Once all slots in use are done, the
// results leave one per cycle while the receiver takes them, one per slot.
// s_tready is low from acceptance until the last result is loaded.
// A load item or an ignored kind leaves the sequencer idle and ready.
// When the receiver stalls, the result register holds its transaction and
// the sequencer waits. At reset the tables are cleared, the slots in use
// become one and both streams are idle.
// ----------------------------------------------------------------------------
module greedy_coin_change_with_stock_unit #(
	parameter int MAX_SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: slots_in_use.
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	// Requests.
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata: slot[2:0], coin_value[12:3], stock_count[22:13], amount[38:23], zero pad
	input  logic [39:0] s_tdata,
	// s_tuser: mode[1:0]
	input  logic [1:0]  s_tuser,
	// Results.
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: slot_res[2:0], dispensed_count[18:3], zero pad
	output logic [23:0] m_tdata,
	// m_tuser: success[0]
	output logic        m_tuser,
	output logic        m_tlast
);

	localparam int LIM   = (MAX_SLOTS < 8) ? MAX_SLOTS : 8;
	localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int N_W   = $clog2(LIM + 1);

	// Tables and registers.
	logic [gccs_pkg::VALUE_W-1:0] value_tbl_q [MAX_SLOTS];
	logic [gccs_pkg::STOCK_W-1:0] stock_tbl_q [MAX_SLOTS];
	logic [gccs_pkg::CNT_W-1:0]   trial_q     [MAX_SLOTS];
	logic [gccs_pkg::CFG_W-1:0]   slots_q;

	gccs_pkg::state_t state_q, state_d;

	logic [N_W-1:0]               idx_q;
	logic [gccs_pkg::AMT_W-1:0]   owed_q;
	logic [gccs_pkg::VALUE_W-1:0] rem_q;
	logic [gccs_pkg::CNT_W-1:0]   quo_q;
	logic [3:0]                   bit_q;
	logic [gccs_pkg::AMT_W-1:0]   prod_q;
	logic                         limited_q;
	logic                         ok_q;

	logic                         out_valid_q;
	logic [gccs_pkg::SLOT_W-1:0]  out_slot_q;
	logic [gccs_pkg::CNT_W-1:0]   out_cnt_q;
	logic                         out_ok_q;
	logic                         out_last_q;

	// Input field unpacking.
	logic [gccs_pkg::SLOT_W-1:0]  in_slot;
	logic [gccs_pkg::VALUE_W-1:0] in_value;
	logic [gccs_pkg::STOCK_W-1:0] in_stock;
	logic [gccs_pkg::AMT_W-1:0]   in_amount;

	assign in_slot   = s_tdata[2:0];
	assign in_value  = s_tdata[12:3];
	assign in_stock  = s_tdata[22:13];
	assign in_amount = s_tdata[38:23];

	// Active slot count: zero counts as one, large values saturate.
	logic [gccs_pkg::CFG_W-1:0] n_cfg;
	logic [N_W-1:0]             n_act;

	always_comb begin
		if (slots_q == '0) begin
			n_cfg = 4'd1;
		end else if (slots_q > 4'(LIM)) begin
			n_cfg = 4'(LIM);
		end else begin
			n_cfg = slots_q;
		end
		n_act = N_W'(n_cfg);
	end

	// Current slot entries.
	logic [IDX_W-1:0]             idx;
	logic [gccs_pkg::VALUE_W-1:0] cur_value;
	logic [gccs_pkg::STOCK_W-1:0] cur_stock;
	logic [gccs_pkg::CNT_W-1:0]   cur_trial;

	assign idx       = IDX_W'(idx_q);
	assign cur_value = value_tbl_q[idx];
	assign cur_stock = stock_tbl_q[idx];
	assign cur_trial = trial_q[idx];

	// Handshake and sequencing conditions.
	logic in_fire;
	logic change_req;
	logic all_done;
	logic out_free;
	logic last_slot;
	logic capped;

	assign in_fire    = s_tvalid && s_tready;
	assign change_req = (s_tuser == gccs_pkg::MODE_LIMITED) || (s_tuser == gccs_pkg::MODE_FREE);
	assign all_done   = (idx_q == n_act);
	assign out_free   = !out_valid_q || m_tready;
	assign last_slot  = (idx_q == n_act - N_W'(1));
	assign capped     = limited_q && (quo_q > {6'd0, cur_stock});

	// One restoring division step: shift in the next dividend bit, subtract if it fits.
	logic [gccs_pkg::VALUE_W:0]   div_trial;
	logic                         div_ge;
	logic [gccs_pkg::VALUE_W:0]   div_diff;
	logic [gccs_pkg::VALUE_W-1:0] div_rem;

	assign div_trial = {rem_q, quo_q[gccs_pkg::CNT_W-1]};
	assign div_ge    = (div_trial >= {1'b0, cur_value});
	assign div_diff  = div_trial - {1'b0, cur_value};
	assign div_rem   = div_ge ? div_diff[gccs_pkg::VALUE_W-1:0]
	                          : div_trial[gccs_pkg::VALUE_W-1:0];

	// Stock times value for a capped slot; it never exceeds the amount owed.
	logic [2*gccs_pkg::VALUE_W-1:0] cap_prod;

	assign cap_prod = cur_stock * cur_value;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			gccs_pkg::ST_IDLE: begin
				if (in_fire && change_req) begin
					state_d = gccs_pkg::ST_SLOT;
				end
			end
			gccs_pkg::ST_SLOT: begin
				if (all_done) begin
					state_d = gccs_pkg::ST_EMIT;
				end else if (cur_value != '0) begin
					state_d = gccs_pkg::ST_DIV;
				end
			end
			gccs_pkg::ST_DIV: begin
				if (bit_q == 4'd0) begin
					state_d = gccs_pkg::ST_FIX;
				end
			end
			gccs_pkg::ST_FIX: begin
				state_d = capped ? gccs_pkg::ST_SUB : gccs_pkg::ST_SLOT;
			end
			gccs_pkg::ST_SUB: begin
				state_d = gccs_pkg::ST_SLOT;
			end
			gccs_pkg::ST_EMIT: begin
				if (out_free && last_slot) begin
					state_d = gccs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gccs_pkg::ST_IDLE;
			end
		endcase
	end

	// Control outputs.
	logic emit_load;

	always_comb begin
		s_tready  = 1'b0;
		emit_load = 1'b0;
		case (state_q)
			gccs_pkg::ST_IDLE: begin
				s_tready = 1'b1;
			end
			gccs_pkg::ST_EMIT: begin
				emit_load = out_free;
			end
			default: begin
				s_tready  = 1'b0;
				emit_load = 1'b0;
			end
		endcase
	end

	// State, configuration and sequencing counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gccs_pkg::ST_IDLE;
			slots_q     <= 4'd1;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				slots_q <= cfg_wdata;
			end
			case (state_q)
				gccs_pkg::ST_IDLE: begin
					idx_q <= '0;
				end
				gccs_pkg::ST_SLOT: begin
					if (all_done) begin
						idx_q <= '0;
					end else if (cur_value == '0) begin
						idx_q <= idx_q + N_W'(1);
					end
				end
				gccs_pkg::ST_FIX: begin
					if (!capped) begin
						idx_q <= idx_q + N_W'(1);
					end
				end
				gccs_pkg::ST_SUB: begin
					idx_q <= idx_q + N_W'(1);
				end
				gccs_pkg::ST_EMIT: begin
					if (emit_load) begin
						idx_q <= idx_q + N_W'(1);
					end
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Coin tables: loads write a slot, a successful limited request takes coins out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SLOTS; i++) begin
				value_tbl_q[i] <= '0;
				stock_tbl_q[i] <= '0;
			end
		end else begin
			if (in_fire && (s_tuser == gccs_pkg::MODE_LOAD) && (int'(in_slot) < MAX_SLOTS)) begin
				value_tbl_q[IDX_W'(in_slot)] <= in_value;
				stock_tbl_q[IDX_W'(in_slot)] <= in_stock;
			end else if (emit_load && ok_q && limited_q) begin
				stock_tbl_q[idx] <= cur_stock - cur_trial[gccs_pkg::STOCK_W-1:0];
			end
		end
	end

	// Divider datapath, owed amount and per-slot trial counts.
	always_ff @(posedge clk) begin
		case (state_q)
			gccs_pkg::ST_IDLE: begin
				owed_q    <= in_amount;
				limited_q <= (s_tuser == gccs_pkg::MODE_LIMITED);
			end
			gccs_pkg::ST_SLOT: begin
				if (all_done) begin
					ok_q <= (owed_q == '0);
				end else if (cur_value == '0) begin
					trial_q[idx] <= '0;
				end else begin
					rem_q <= '0;
					quo_q <= owed_q;
					bit_q <= 4'd15;
				end
			end
			gccs_pkg::ST_DIV: begin
				rem_q <= div_rem;
				quo_q <= {quo_q[gccs_pkg::CNT_W-2:0], div_ge};
				bit_q <= bit_q - 4'd1;
			end
			gccs_pkg::ST_FIX: begin
				if (capped) begin
					prod_q <= cap_prod[gccs_pkg::AMT_W-1:0];
				end else begin
					trial_q[idx] <= quo_q;
					owed_q       <= {6'd0, rem_q};
				end
			end
			gccs_pkg::ST_SUB: begin
				trial_q[idx] <= {6'd0, cur_stock};
				owed_q       <= owed_q - prod_q;
			end
			default: begin
				owed_q <= owed_q;
			end
		endcase
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_slot_q <= gccs_pkg::SLOT_W'(idx_q);
			out_cnt_q  <= ok_q ? cur_trial : '0;
			out_ok_q   <= ok_q;
			out_last_q <= last_slot;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_cnt_q, out_slot_q};
	assign m_tuser  = out_ok_q;
	assign m_tlast  = out_last_q;

endmodule

### hdl/gccs_checker.sv
// ----------------------------------------------------------------------------
// gccs_checker
// Port-level checks for the greedy coin change unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "greedy_coin_change_with_stock_unit_defines.svh"

module gccs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// Helper terms for the checks below.
	logic        out_stall;
	logic [25:0] out_word;
	logic [15:0] out_cnt;
	logic        chg_fire;

	assign out_stall = m_tvalid && !m_tready;
	assign out_word  = {m_tuser, m_tlast, m_tdata};
	assign out_cnt   = m_tdata[18:3];
	assign chg_fire  = s_tvalid && s_tready &&
	                   ((s_tuser == gccs_pkg::MODE_LIMITED) || (s_tuser == gccs_pkg::MODE_FREE));

	// A stalled result transaction keeps its payload.
	`GCCS_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(out_word), "stalled result changed")

	// A failed request reports no coins.
	`GCCS_ASSERT_NOW(a_fail_zero, m_tvalid && !m_tuser, out_cnt == '0, "failed result has coins")

	// The sequencer is busy right after it takes a change request.
	`GCCS_ASSERT_NEXT(a_busy, chg_fire, !s_tready, "ready while working on a request")

	// Results never carry a set padding bit.
	`GCCS_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[23:19] == 5'd0, "result padding not zero")

endmodule

bind greedy_coin_change_with_stock_unit gccs_checker u_gccs_checker (.*);
